// File: src/ptt_pkg.sv
// Package for the partition table translator: widths, codes, status, state and table entry types.
package ptt_pkg;

    localparam int PT_MAX_PARTS = 8;
    localparam int PT_NUM_W     = 64;
    localparam int PT_ID_W      = 8;

    // Mode codes of an input transfer (5 to 7 are unused)
    localparam logic [2:0] MODE_CLEAR      = 3'd0;
    localparam logic [2:0] MODE_CREATE     = 3'd1;
    localparam logic [2:0] MODE_LOOKUP     = 3'd2;
    localparam logic [2:0] MODE_TO_LAYER   = 3'd3;
    localparam logic [2:0] MODE_FROM_LAYER = 3'd4;

    // Configuration register indexes
    localparam logic CFG_LAYOUT_START  = 1'b0;
    localparam logic CFG_LAYOUT_BLOCKS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_EXISTS   = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_RANGE    = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPACE,
        S_WALK,
        S_XLATE,
        S_RANGE,
        S_COMMIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [PT_ID_W-1:0]  id;
        logic [PT_NUM_W-1:0] offset;
        logic [PT_NUM_W-1:0] base;
        logic [PT_NUM_W-1:0] count;
    } t_entry;

endpackage

// File: src/partition_table_translator.sv
// Partition table translator: free range, partition table memory and translation sequencer.
//
//   Channel   | Direction | Handshake                    | Payload
//   ----------+-----------+------------------------------+----------------------------------
//   input     | in        | i_valid / o_ready            | i_mode .. i_block_number
//   result    | out       | o_valid / i_ready            | o_status .. o_unused_blocks
//   config    | in        | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// Order: one item at a time. Clear, identity and unused modes go from idle straight to the
//   emit state. Lookups, translations and creates walk the table memory one entry a
//   cycle; the one-read-port walk sets this pace.
// Reset: synchronous, active low; empties the table (valid bits only), zeroes the free
//   range and the layout registers. Table memory contents are not cleared.
// Stalls: the finished result sits in the output register; the next transfer is taken
//   while it waits, and only the write into the output register holds off.
module partition_table_translator
    import ptt_pkg::*;
#(
    parameter int MAX_PARTITIONS = PT_MAX_PARTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [PT_NUM_W-1:0] i_cfg_data,
    // input channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_mode,
    input  logic [PT_ID_W-1:0]  i_partition_id,
    input  logic                i_no_partition,
    input  logic [PT_NUM_W-1:0] i_block_count,
    input  logic                i_take_all,
    input  logic                i_carve_tail,
    input  logic [PT_NUM_W-1:0] i_base_number,
    input  logic [PT_NUM_W-1:0] i_block_number,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [PT_NUM_W-1:0] o_result_block,
    output logic [PT_NUM_W-1:0] o_part_offset,
    output logic [PT_NUM_W-1:0] o_part_base,
    output logic [PT_NUM_W-1:0] o_part_count,
    output logic [PT_NUM_W-1:0] o_unused_blocks
);

    localparam int IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CW = $clog2(MAX_PARTITIONS + 1);

    // partition table: one synchronous memory, one write and one read port
    t_entry mem [MAX_PARTITIONS];
    t_entry r_rd;
    logic   rd_en;
    logic   mem_we;
    t_entry wr_entry;

    // control state
    t_state                    r_state, n_state;
    logic [MAX_PARTITIONS-1:0] r_valid, n_valid;
    logic [PT_NUM_W-1:0]       r_first, n_first;
    logic [PT_NUM_W-1:0]       r_end, n_end;
    logic [PT_NUM_W-1:0]       r_free, n_free;     // always r_end - r_first
    logic [PT_NUM_W-1:0]       r_lstart, n_lstart;
    logic [PT_NUM_W-1:0]       r_lblocks, n_lblocks;
    logic [CW-1:0]             r_idx, n_idx;       // next entry to read
    logic                      r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]             r_cmp_idx, n_cmp_idx; // entry whose data is in r_rd
    logic                      r_free_found, n_free_found;
    logic [IW-1:0]             r_free_idx, n_free_idx;
    logic                      r_o_vld, n_o_vld;

    // captured item
    logic [2:0]          r_mode, n_mode;
    logic [PT_ID_W-1:0]  r_id, n_id;
    logic [PT_NUM_W-1:0] r_count, n_count;
    logic                r_take_all, n_take_all;
    logic                r_carve_tail, n_carve_tail;
    logic [PT_NUM_W-1:0] r_base, n_base;
    logic [PT_NUM_W-1:0] r_blk, n_blk;

    // pending result
    t_status             r_status, n_status;
    logic [PT_NUM_W-1:0] r_result, n_result;
    logic [PT_NUM_W-1:0] r_poff, n_poff;
    logic [PT_NUM_W-1:0] r_pbase, n_pbase;
    logic [PT_NUM_W-1:0] r_pcnt, n_pcnt;
    logic [PT_NUM_W-1:0] r_diff, n_diff;
    logic                r_below, n_below;

    // output register
    logic [2:0]          r_o_status, n_o_status;
    logic [PT_NUM_W-1:0] r_o_result, n_o_result;
    logic [PT_NUM_W-1:0] r_o_poff, n_o_poff;
    logic [PT_NUM_W-1:0] r_o_pbase, n_o_pbase;
    logic [PT_NUM_W-1:0] r_o_pcnt, n_o_pcnt;
    logic [PT_NUM_W-1:0] r_o_free, n_o_free;

    logic                walk_hit;
    logic                walk_free;
    logic                walk_last;
    logic [PT_NUM_W-1:0] commit_off;
    logic [PT_NUM_W-1:0] xlate_sel;

    // compare stage of the walk: r_rd holds entry r_cmp_idx
    assign walk_hit   = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd.id == r_id);
    assign walk_free  = r_cmp_vld && !r_valid[r_cmp_idx];
    assign walk_last  = r_cmp_vld && (r_cmp_idx == IW'(MAX_PARTITIONS - 1));
    assign commit_off = r_carve_tail ? (r_end - r_count) : r_first;
    assign xlate_sel  = (r_mode == MODE_TO_LAYER) ? r_pbase : r_poff;

    assign wr_entry = '{id: r_id, offset: commit_off, base: r_base, count: r_count};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_free_idx] <= wr_entry;
        end
        if (rd_en) begin
            r_rd <= mem[r_idx[IW-1:0]];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_first      = r_first;
        n_end        = r_end;
        n_free       = r_free;
        n_lstart     = r_lstart;
        n_lblocks    = r_lblocks;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_o_vld      = r_o_vld && !i_ready;
        n_mode       = r_mode;
        n_id         = r_id;
        n_count      = r_count;
        n_take_all   = r_take_all;
        n_carve_tail = r_carve_tail;
        n_base       = r_base;
        n_blk        = r_blk;
        n_status     = r_status;
        n_result     = r_result;
        n_poff       = r_poff;
        n_pbase      = r_pbase;
        n_pcnt       = r_pcnt;
        n_diff       = r_diff;
        n_below      = r_below;
        n_o_status   = r_o_status;
        n_o_result   = r_o_result;
        n_o_poff     = r_o_poff;
        n_o_pbase    = r_o_pbase;
        n_o_pcnt     = r_o_pcnt;
        n_o_free     = r_o_free;
        rd_en        = 1'b0;
        mem_we       = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAYOUT_START:  n_lstart  = i_cfg_data;
                CFG_LAYOUT_BLOCKS: n_lblocks = i_cfg_data;
                default:           n_lstart  = r_lstart;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode       = i_mode;
                    n_id         = i_partition_id;
                    n_count      = i_block_count;
                    n_take_all   = i_take_all;
                    n_carve_tail = i_carve_tail;
                    n_base       = i_base_number;
                    n_blk        = i_block_number;
                    n_status     = ST_OK;
                    n_result     = '0;
                    n_poff       = '0;
                    n_pbase      = '0;
                    n_pcnt       = '0;
                    n_idx        = '0;
                    n_cmp_vld    = 1'b0;
                    n_free_found = 1'b0;
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_valid = '0;
                            n_first = r_lstart;
                            n_end   = r_lstart + r_lblocks;
                            n_free  = r_lblocks;
                            n_state = S_EMIT;
                        end
                        MODE_CREATE: n_state = S_SPACE;
                        MODE_LOOKUP: n_state = S_WALK;
                        MODE_TO_LAYER, MODE_FROM_LAYER: begin
                            if (i_no_partition) begin
                                n_result = i_block_number;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_SPACE: begin
                if (r_take_all ? (r_free == '0) : (r_count > r_free)) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_EMIT;
                end else begin
                    if (r_take_all) begin
                        n_count = r_free;
                    end
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // read stage
                if (r_idx < CW'(MAX_PARTITIONS)) begin
                    rd_en     = 1'b1;
                    n_idx     = r_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                // compare stage
                if (walk_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                if (walk_hit) begin
                    if (r_mode == MODE_CREATE) begin
                        n_status = ST_EXISTS;
                        n_state  = S_EMIT;
                    end else begin
                        n_poff  = r_rd.offset;
                        n_pbase = r_rd.base;
                        n_pcnt  = r_rd.count;
                        n_state = (r_mode == MODE_LOOKUP) ? S_EMIT : S_XLATE;
                    end
                end else if (walk_last) begin
                    if (r_mode == MODE_CREATE) begin
                        if (r_free_found || walk_free) begin
                            n_state = S_COMMIT;
                        end else begin
                            n_status = ST_FULL;
                            n_state  = S_EMIT;
                        end
                    end else begin
                        n_status = ST_UNKNOWN;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_XLATE: begin
                n_diff  = r_blk - xlate_sel;
                n_below = r_blk < xlate_sel;
                n_state = S_RANGE;
            end
            S_RANGE: begin
                if (r_below || (r_diff >= r_pcnt)) begin
                    n_status = ST_RANGE;
                end else begin
                    n_result = ((r_mode == MODE_TO_LAYER) ? r_poff : r_pbase) + r_diff;
                end
                n_state = S_EMIT;
            end
            S_COMMIT: begin
                mem_we              = 1'b1;
                n_valid[r_free_idx] = 1'b1;
                if (r_carve_tail) begin
                    n_end = commit_off;
                end else begin
                    n_first = r_first + r_count;
                end
                n_free  = r_free - r_count;
                n_poff  = commit_off;
                n_pbase = r_base;
                n_pcnt  = r_count;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_o_vld || i_ready) begin
                    n_o_vld    = 1'b1;
                    n_o_status = r_status;
                    n_o_result = r_result;
                    n_o_poff   = r_poff;
                    n_o_pbase  = r_pbase;
                    n_o_pcnt   = r_pcnt;
                    n_o_free   = r_free;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_first      <= '0;
            r_end        <= '0;
            r_free       <= '0;
            r_lstart     <= '0;
            r_lblocks    <= '0;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_first      <= n_first;
            r_end        <= n_end;
            r_free       <= n_free;
            r_lstart     <= n_lstart;
            r_lblocks    <= n_lblocks;
            r_idx        <= n_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_free_found <= n_free_found;
            r_o_vld      <= n_o_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx    <= n_cmp_idx;
        r_free_idx   <= n_free_idx;
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_count      <= n_count;
        r_take_all   <= n_take_all;
        r_carve_tail <= n_carve_tail;
        r_base       <= n_base;
        r_blk        <= n_blk;
        r_status     <= n_status;
        r_result     <= n_result;
        r_poff       <= n_poff;
        r_pbase      <= n_pbase;
        r_pcnt       <= n_pcnt;
        r_diff       <= n_diff;
        r_below      <= n_below;
        r_o_status   <= n_o_status;
        r_o_result   <= n_o_result;
        r_o_poff     <= n_o_poff;
        r_o_pbase    <= n_o_pbase;
        r_o_pcnt     <= n_o_pcnt;
        r_o_free     <= n_o_free;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_vld;
    assign o_status        = r_o_status;
    assign o_result_block  = r_o_result;
    assign o_part_offset   = r_o_poff;
    assign o_part_base     = r_o_pbase;
    assign o_part_count    = r_o_pcnt;
    assign o_unused_blocks = r_o_free;

    // free count tracks the range it summarises
    a_free_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free == (r_end - r_first))
        else $error("free count out of step with free range");

    // a create only ever writes into an empty slot found by the walk
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> (r_free_found && !r_valid[r_free_idx]))
        else $error("create commits into an occupied slot");

    // each commit adds exactly one table entry
    a_commit_adds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("commit did not add exactly one entry");

    // a result appears only out of the emit state
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_vld) |-> ($past(r_state) == S_EMIT))
        else $error("result register loaded outside emit");

endmodule
